### hw/rtl/bcal_pkg.sv
package bcal_pkg;

    localparam int unsigned MaxSlots   = 1024;
    localparam int unsigned MaxExtents = 64;
    localparam int unsigned OffW       = $clog2(MaxSlots);
    localparam int unsigned CntW       = OffW + 1;
    localparam int unsigned IdxW       = $clog2(MaxExtents);
    localparam int unsigned SumW       = CntW + 1;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [0:0] REG_PAGE_SIZE = 1'b0;

    typedef struct packed {
        logic            valid;
        logic [OffW-1:0] start;
        logic [CntW-1:0] len;
    } t_ext;

endpackage

### hw/rtl/bcal_req_if.sv
interface bcal_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [bcal_pkg::OffW-1:0]     block_offset;
    logic [bcal_pkg::CntW-1:0]     block_count;

    modport source (output valid, output cmd, output block_offset, output block_count,
                    input ready);
    modport sink   (input valid, input cmd, input block_offset, input block_count,
                    output ready);
endinterface

### hw/rtl/bcal_rsp_if.sv
interface bcal_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [bcal_pkg::OffW-1:0]     alloc_offset;
    logic [bcal_pkg::CntW-1:0]     free_total;

    modport source (output valid, output status, output alloc_offset, output free_total,
                    input ready);
    modport sink   (input valid, input status, input alloc_offset, input free_total,
                    output ready);
endinterface

### hw/rtl/best_fit_coalescing_block_allocator_top.sv
// best-fit extent allocator: the free extents live in a ring of 64 cells that
// rotates one place per cycle during the scan and update laps, so every entry
// passes the head cell in turn. each request takes a full scan lap to find the
// best fit or the merge neighbors, a decision state, and for a successful
// request a second lap that rewrites the chosen entries as they pass the head.
// one request is in flight at a time; the result sits in an output register
// and the next request is taken while it waits.
// a write of page_size (byte address 0) reinitializes the table to one free
// extent covering the page; only bits 10:0 of the data are used, 0 is taken as
// 1 and values above 1024 as 1024.
module best_fit_coalescing_block_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bcal_req_if.sink                  i_req,
    bcal_rsp_if.source                o_rsp,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [2:0]                i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output logic                      o_pready
);
    localparam int unsigned OffW = bcal_pkg::OffW;
    localparam int unsigned CntW = bcal_pkg::CntW;
    localparam int unsigned IdxW = bcal_pkg::IdxW;
    localparam int unsigned SumW = bcal_pkg::SumW;
    localparam int unsigned NExt = bcal_pkg::MaxExtents;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DEC  = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // config
    logic            w_cfg_wr;
    logic [CntW-1:0] w_page_wr;
    logic [CntW-1:0] r_page;
    logic            w_init;
    logic [CntW-1:0] w_init_page;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite
                      && (i_paddr[2] == bcal_pkg::REG_PAGE_SIZE);
    assign o_prdata = {{(32-CntW){1'b0}}, r_page};

    always_comb begin
        w_page_wr = i_pwdata[CntW-1:0];
        if (w_page_wr == '0) begin
            w_page_wr = CntW'(1);
        end else if (w_page_wr > CntW'(bcal_pkg::MaxSlots)) begin
            w_page_wr = CntW'(bcal_pkg::MaxSlots);
        end
    end

    assign w_init      = !i_rst_n || w_cfg_wr;
    assign w_init_page = !i_rst_n ? CntW'(bcal_pkg::MaxSlots) : w_page_wr;

    // request capture
    logic            r_cmd;
    logic [OffW-1:0] r_off;
    logic [CntW-1:0] r_cnt;
    logic [SumW-1:0] w_end;
    logic [CntW-1:0] r_free;

    assign w_end = SumW'(r_off) + SumW'(r_cnt);

    // ring of cells
    bcal_pkg::t_ext w_ext [NExt];
    bcal_pkg::t_ext w_tail_in;
    bcal_pkg::t_ext w_head;
    bcal_pkg::t_ext w_mod;
    logic           w_shift;

    assign w_shift = (r_state == S_SCAN) || (r_state == S_UPD);
    assign w_head  = w_ext[0];

    genvar g;
    generate
        for (g = 0; g < NExt; g++) begin : g_cell
            bcal_pkg::t_ext w_ival;
            bcal_pkg::t_ext w_nbr;
            assign w_ival = (g == 0)
                ? bcal_pkg::t_ext'{valid: 1'b1, start: '0, len: w_init_page}
                : bcal_pkg::t_ext'{valid: 1'b0, start: '0, len: '0};
            if (g == NExt - 1) begin : g_tail
                assign w_nbr = w_tail_in;
            end else begin : g_mid
                assign w_nbr = w_ext[g+1];
            end
            bcal_cell u_cell (
                .i_clk      (i_clk),
                .i_init     (w_init),
                .i_init_val (w_ival),
                .i_shift    (w_shift),
                .i_nbr      (w_nbr),
                .o_ext      (w_ext[g])
            );
        end
    endgenerate

    // lap position: entry r_idx is at the head
    logic [IdxW-1:0] r_idx;

    // scan results
    logic            r_best_f;
    logic [IdxW-1:0] r_best;
    logic [CntW-1:0] r_best_len;
    logic [OffW-1:0] r_best_start;
    logic            r_ovl;
    logic            r_prev_f, r_next_f, r_empty_f;
    logic [IdxW-1:0] r_prev, r_next, r_empty;
    logic [CntW-1:0] r_next_len;
    logic [1:0]      r_status;

    logic [SumW-1:0] w_h_end;
    logic            w_fit, w_better;

    assign w_h_end  = SumW'(w_head.start) + SumW'(w_head.len);
    assign w_fit    = w_head.valid && (w_head.len >= r_cnt);
    assign w_better = !r_best_f || (w_head.len < r_best_len)
                      || ((w_head.len == r_best_len) && (w_head.start < r_best_start));

    // head rewrite during the update lap
    always_comb begin
        w_mod = w_head;
        if (r_cmd == bcal_pkg::CMD_ALLOC) begin
            if (r_idx == r_best) begin
                w_mod.start = w_head.start + r_cnt[OffW-1:0];
                w_mod.len   = w_head.len - r_cnt;
                if (w_head.len == r_cnt) begin
                    w_mod.valid = 1'b0;
                    w_mod.start = '0;
                end
            end
        end else begin
            if (r_prev_f && (r_idx == r_prev)) begin
                w_mod.len = w_head.len + r_cnt + (r_next_f ? r_next_len : '0);
            end else if (r_next_f && (r_idx == r_next)) begin
                if (r_prev_f) begin
                    w_mod = '{valid: 1'b0, start: '0, len: '0};
                end else begin
                    w_mod.start = r_off;
                    w_mod.len   = w_head.len + r_cnt;
                end
            end else if (!r_prev_f && !r_next_f && r_empty_f && (r_idx == r_empty)) begin
                w_mod = '{valid: 1'b1, start: r_off, len: r_cnt};
            end
        end
    end

    assign w_tail_in = (r_state == S_UPD) ? w_mod : w_head;

    // decision from the scan
    logic [1:0] w_dec;
    always_comb begin
        if (r_cmd == bcal_pkg::CMD_ALLOC) begin
            w_dec = (r_cnt == '0 || r_cnt > r_free || !r_best_f) ? bcal_pkg::ST_REFUSED
                                                                 : bcal_pkg::ST_OK;
        end else if (r_cnt == '0 || w_end > SumW'(r_page) || r_ovl) begin
            w_dec = bcal_pkg::ST_REFUSED;
        end else if (!r_prev_f && !r_next_f && !r_empty_f) begin
            w_dec = bcal_pkg::ST_FULL;
        end else begin
            w_dec = bcal_pkg::ST_OK;
        end
    end

    // output register
    logic            r_ovalid;
    logic [1:0]      r_ostat;
    logic [OffW-1:0] r_ooff;
    logic [CntW-1:0] r_ofree;

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.alloc_offset = r_ooff;
    assign o_rsp.free_total   = r_ofree;

    logic w_out_free;
    assign w_out_free = !r_ovalid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SCAN;
            S_SCAN: if (r_idx == IdxW'(NExt - 1)) n_state = S_DEC;
            S_DEC:  n_state = (w_dec == bcal_pkg::ST_OK) ? S_UPD : S_DONE;
            S_UPD:  if (r_idx == IdxW'(NExt - 1)) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_page   <= CntW'(bcal_pkg::MaxSlots);
            r_free   <= CntW'(bcal_pkg::MaxSlots);
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_page <= w_page_wr;
                r_free <= w_page_wr;
            end
            if (w_shift) begin
                r_idx <= r_idx + IdxW'(1);
            end
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_DEC) && (w_dec == bcal_pkg::ST_OK)) begin
                r_free <= (r_cmd == bcal_pkg::CMD_ALLOC) ? r_free - r_cnt : r_free + r_cnt;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req.valid) begin
            r_cmd        <= i_req.cmd;
            r_off        <= i_req.block_offset;
            r_cnt        <= i_req.block_count;
            r_best_f     <= 1'b0;
            r_best       <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_ovl        <= 1'b0;
            r_prev_f     <= 1'b0;
            r_next_f     <= 1'b0;
            r_empty_f    <= 1'b0;
            r_prev       <= '0;
            r_next       <= '0;
            r_empty      <= '0;
            r_next_len   <= '0;
        end
        if (r_state == S_SCAN) begin
            if (w_fit && w_better) begin
                r_best_f     <= 1'b1;
                r_best       <= r_idx;
                r_best_len   <= w_head.len;
                r_best_start <= w_head.start;
            end
            if (!w_head.valid) begin
                if (!r_empty_f) begin
                    r_empty_f <= 1'b1;
                    r_empty   <= r_idx;
                end
            end else begin
                if ((SumW'(w_head.start) < w_end) && (SumW'(r_off) < w_h_end)) begin
                    r_ovl <= 1'b1;
                end
                if (w_h_end == SumW'(r_off)) begin
                    r_prev_f <= 1'b1;
                    r_prev   <= r_idx;
                end
                if (SumW'(w_head.start) == w_end) begin
                    r_next_f   <= 1'b1;
                    r_next     <= r_idx;
                    r_next_len <= w_head.len;
                end
            end
        end
        if (r_state == S_DEC) begin
            r_status <= w_dec;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_ostat <= r_status;
            r_ooff  <= ((r_cmd == bcal_pkg::CMD_ALLOC) && (r_status == bcal_pkg::ST_OK))
                       ? r_best_start : '0;
            r_ofree <= r_free;
        end
    end
endmodule

### hw/rtl/bcal_cell.sv
module bcal_cell (
    input  logic           i_clk,
    input  logic           i_init,
    input  bcal_pkg::t_ext i_init_val,
    input  logic           i_shift,
    input  bcal_pkg::t_ext i_nbr,
    output bcal_pkg::t_ext o_ext
);
    bcal_pkg::t_ext r_ext;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_ext <= i_init_val;
        end else if (i_shift) begin
            r_ext <= i_nbr;
        end
    end

    assign o_ext = r_ext;
endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one allocate or free request
    typedef struct packed {
        logic                      cmd;
        logic [bcal_pkg::OffW-1:0] offset;
        logic [bcal_pkg::CntW-1:0] count;
    } t_request;

    // one response from the allocator
    typedef struct packed {
        logic [1:0]                status;
        logic [bcal_pkg::OffW-1:0] offset;
        logic [bcal_pkg::CntW-1:0] total;
    } t_answer;

    // limit: scan and update laps per request, worst-case stalls, then several times over
    localparam int unsigned CycleLimit = 4_000_000;
    localparam int unsigned DrainCycles = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [2:0] i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic o_pready;

    bcal_req_if req_if ();
    bcal_rsp_if rsp_if ();

    best_fit_coalescing_block_allocator_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // shadow copy of the allocator state
    int unsigned             page_slots;
    logic [bcal_pkg::OffW:0] ext_start [bcal_pkg::MaxExtents];
    logic [bcal_pkg::OffW:0] ext_len   [bcal_pkg::MaxExtents];
    bit                      ext_used  [bcal_pkg::MaxExtents];
    int unsigned             slots_free;

    t_request pending_reqs [$];
    t_answer  expected_answers [$];
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // idle percentages, changed by the stimulus phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold_cycles;
    bit          recv_hold_req;

    // live allocations, so frees mostly return real extents
    int unsigned held_off [$];
    int unsigned held_cnt [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void reset_table(int unsigned size);
        for (int i = 0; i < bcal_pkg::MaxExtents; i++) begin
            ext_start[i] = '0;
            ext_len[i] = '0;
            ext_used[i] = 1'b0;
        end
        page_slots = size;
        ext_used[0] = 1'b1;
        ext_len[0] = bcal_pkg::CntW'(size);
        slots_free = size;
    endfunction

    // best-fit allocate, coalescing free
    function automatic t_answer predict_answer(t_request r);
        t_answer a;
        int best;
        int prv;
        int nxt;
        int hole;
        int unsigned s;
        int unsigned e;
        int unsigned fin;
        a = '0;
        best = -1;
        prv = -1;
        nxt = -1;
        hole = -1;
        if (r.cmd == bcal_pkg::CMD_ALLOC) begin
            a.status = bcal_pkg::ST_REFUSED;
            if (r.count != 0 && r.count <= slots_free) begin
                for (int i = 0; i < bcal_pkg::MaxExtents; i++) begin
                    if (ext_used[i] && ext_len[i] >= r.count) begin
                        if (best < 0 || ext_len[i] < ext_len[best] ||
                            (ext_len[i] == ext_len[best] && ext_start[i] < ext_start[best]))
                            best = i;
                    end
                end
                if (best >= 0) begin
                    a.status = bcal_pkg::ST_OK;
                    a.offset = ext_start[best][bcal_pkg::OffW-1:0];
                    ext_start[best] += r.count;
                    ext_len[best] -= r.count;
                    if (ext_len[best] == 0) begin
                        ext_used[best] = 1'b0;
                        ext_start[best] = '0;
                    end
                    slots_free -= r.count;
                end
            end
        end else begin
            fin = 32'(r.offset) + 32'(r.count);
            a.status = bcal_pkg::ST_OK;
            if (r.count == 0 || fin > page_slots) a.status = bcal_pkg::ST_REFUSED;
            for (int i = 0; i < bcal_pkg::MaxExtents && a.status == bcal_pkg::ST_OK; i++) begin
                if (!ext_used[i]) begin
                    if (hole < 0) hole = i;
                end else begin
                    s = 32'(ext_start[i]);
                    e = s + 32'(ext_len[i]);
                    if (s < fin && r.offset < e) a.status = bcal_pkg::ST_REFUSED;
                    if (e == r.offset) prv = i;
                    if (s == fin) nxt = i;
                end
            end
            if (a.status == bcal_pkg::ST_OK) begin
                if (prv >= 0 && nxt >= 0) begin
                    ext_len[prv] += r.count + ext_len[nxt];
                    ext_used[nxt] = 1'b0;
                    ext_start[nxt] = '0;
                    ext_len[nxt] = '0;
                end else if (prv >= 0) begin
                    ext_len[prv] += r.count;
                end else if (nxt >= 0) begin
                    ext_start[nxt] = (bcal_pkg::OffW+1)'(r.offset);
                    ext_len[nxt] += r.count;
                end else if (hole < 0) begin
                    a.status = bcal_pkg::ST_FULL;
                end else begin
                    ext_used[hole] = 1'b1;
                    ext_start[hole] = (bcal_pkg::OffW+1)'(r.offset);
                    ext_len[hole] = r.count;
                end
                if (a.status == bcal_pkg::ST_OK) slots_free += r.count;
            end
        end
        a.total = bcal_pkg::CntW'(slots_free);
        return a;
    endfunction

    // request driver: pops the pending queue, random gaps between requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) expected_answers.push_back(predict_answer(
                    {req_if.cmd, req_if.block_offset, req_if.block_count}));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_request r;
                r = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.cmd <= r.cmd;
                req_if.block_offset <= r.offset;
                req_if.block_count <= r.count;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response monitor: random ready, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            recv_hold_cycles <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_answer got;
                t_answer want;
                got = {rsp_if.status, rsp_if.alloc_offset, rsp_if.free_total};
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual %h", $time, got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status || got.offset !== want.offset ||
                        got.total !== want.total) begin
                        $display("%0t: expected status %0d offset %0d total %0d, actual %0d %0d %0d",
                                 $time, want.status, want.offset, want.total,
                                 got.status, got.offset, got.total);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (recv_hold_req && recv_hold_cycles == 0) begin
                recv_hold_cycles <= 2000;
                rsp_if.ready <= 1'b0;
            end else if (recv_hold_cycles > 0) begin
                recv_hold_cycles <= recv_hold_cycles - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= addr;
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    // wait until every response is back, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_page(input int unsigned raw);
        int unsigned size;
        drain();
        apb_write({bcal_pkg::REG_PAGE_SIZE, 2'b00}, raw);
        size = raw & 11'h7FF;
        if (size == 0) size = 1;
        if (size > bcal_pkg::MaxSlots) size = bcal_pkg::MaxSlots;
        reset_table(size);
        held_off.delete();
        held_cnt.delete();
    endtask

    task automatic add_req(input logic cmd, input int unsigned off, input int unsigned cnt);
        pending_reqs.push_back({cmd, off[bcal_pkg::OffW-1:0], cnt[bcal_pkg::CntW-1:0]});
    endtask

    // mostly realistic allocate/free traffic, small counts so the table fragments
    task automatic random_traffic(input int unsigned n);
        int unsigned k;
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                k = ($urandom_range(9) == 0) ? $urandom_range(1, page_slots)
                                             : $urandom_range(1, 12);
                add_req(bcal_pkg::CMD_ALLOC, $urandom, k);
                held_off.push_back($urandom_range(page_slots - 1));
                held_cnt.push_back(k);
            end else if (pick < 85 && held_off.size() > 0) begin
                // free part of a guessed live region; predictor settles legality
                k = $urandom_range(held_off.size() - 1);
                add_req(bcal_pkg::CMD_FREE, held_off[k], $urandom_range(1, held_cnt[k]));
                held_off.delete(k);
                held_cnt.delete(k);
            end else begin
                add_req(1'($urandom_range(1)), $urandom, $urandom_range(0, 2047));
            end
        end
    endtask

    // alloc in 1-slot units then free every other one to fill the table
    task automatic fragment_fill(input int unsigned n);
        for (int i = 0; i < n; i++) add_req(bcal_pkg::CMD_ALLOC, 0, 1);
        for (int i = 0; i < n; i += 2) add_req(bcal_pkg::CMD_FREE, i, 1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        req_if.valid = 1'b0;
        req_if.cmd = 1'b0;
        req_if.block_offset = '0;
        req_if.block_count = '0;
        rsp_if.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        recv_hold_req = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 80;
        reset_table(bcal_pkg::MaxSlots);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: refusals, whole-page grab, bad frees, merges both sides
        add_req(bcal_pkg::CMD_ALLOC, 0, 0);
        add_req(bcal_pkg::CMD_ALLOC, 10'h3FF, 1025);
        add_req(bcal_pkg::CMD_ALLOC, 0, 2047);
        add_req(bcal_pkg::CMD_ALLOC, 0, 1024);
        add_req(bcal_pkg::CMD_ALLOC, 0, 1);
        add_req(bcal_pkg::CMD_FREE, 0, 0);
        add_req(bcal_pkg::CMD_FREE, 1023, 2);
        add_req(bcal_pkg::CMD_FREE, 100, 50);
        add_req(bcal_pkg::CMD_FREE, 300, 50);
        add_req(bcal_pkg::CMD_FREE, 200, 50);
        add_req(bcal_pkg::CMD_FREE, 250, 50);
        add_req(bcal_pkg::CMD_FREE, 150, 50);
        add_req(bcal_pkg::CMD_FREE, 120, 10);
        add_req(bcal_pkg::CMD_ALLOC, 0, 250);
        add_req(bcal_pkg::CMD_ALLOC, 0, 5);
        add_req(bcal_pkg::CMD_FREE, 1023, 1);
        add_req(bcal_pkg::CMD_FREE, 0, 100);
        add_req(bcal_pkg::CMD_ALLOC, 0, 1000);

        // sender pauses until everything is back
        drain();
        set_page(0);
        add_req(bcal_pkg::CMD_ALLOC, 0, 1);
        add_req(bcal_pkg::CMD_ALLOC, 0, 1);
        add_req(bcal_pkg::CMD_FREE, 0, 1);
        set_page(2047);
        // full table: more isolated holes than entries
        fragment_fill(140);
        random_traffic(60);

        set_page(96);
        random_traffic(400);

        // receiver holds off while requests keep coming
        recv_hold_req = 1'b1;
        random_traffic(60);
        repeat (2) @(posedge i_clk);
        recv_hold_req = 1'b0;

        send_idle_pct = 80;
        recv_idle_pct = 37;
        set_page(1);
        random_traffic(40);
        set_page(1024);
        random_traffic(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_page(300);
        random_traffic(400);
        drain();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### best_fit_coalescing_block_allocator_top.f
hw/rtl/bcal_pkg.sv
hw/rtl/bcal_req_if.sv
hw/rtl/bcal_rsp_if.sv
hw/rtl/bcal_cell.sv
hw/rtl/best_fit_coalescing_block_allocator_top.sv
tb/sv/tb.sv
